### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on i_clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define DRLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define DRLM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hw/rtl/drlm_pkg.sv
// ---------------------------------------------------------------------------
// drlm_pkg
// Types, sizes and rectangle helpers for the dirty rectangle list merger.
// ---------------------------------------------------------------------------
`default_nettype none

package drlm_pkg;

    localparam int MAX_RECTS  = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [IDX_W-1:0]             t_idx;

    typedef struct packed {
        t_coord l;
        t_coord t;
        t_coord r;
        t_coord b;
    } t_rect;

    typedef enum logic [1:0] {
        F_ADD   = 2'd0,
        F_MERGE = 2'd1,
        F_CLEAR = 2'd2,
        F_DUMP  = 2'd3
    } t_func;

    // strict, non-empty intersection
    function automatic logic rect_ovl(input t_rect a, input t_rect b);
        t_coord il, it, ir, ib;
        il = (a.l > b.l) ? a.l : b.l;
        it = (a.t > b.t) ? a.t : b.t;
        ir = (a.r < b.r) ? a.r : b.r;
        ib = (a.b < b.b) ? a.b : b.b;
        return (il < ir) && (it < ib);
    endfunction

    // bounding box of both
    function automatic t_rect rect_union(input t_rect a, input t_rect b);
        t_rect u;
        u.l = (b.l < a.l) ? b.l : a.l;
        u.t = (b.t < a.t) ? b.t : a.t;
        u.r = (b.r > a.r) ? b.r : a.r;
        u.b = (b.b > a.b) ? b.b : a.b;
        return u;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/drlm_ram.sv
// ---------------------------------------------------------------------------
// drlm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module drlm_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/dirty_rect_list_merger.sv
// ---------------------------------------------------------------------------
// dirty_rect_list_merger
// Bounded list of dirty rectangles, newest first, with add, merge, clear and
// dump operations. The list lives in a small RAM used as a ring: the head
// pointer moves back on a push, so entry 0 is always the newest one. One
// word in gives one result word, except dump, which gives one word per entry
// (or a single empty word when the list is empty); is_last marks the final
// word of each operation. Merge walks pairs (i, j) with one RAM read port
// and one shared compare/union unit. Every union rewrites entry i, shifts
// the tail down one place and rescans from the front. The input is not
// ready while an operation is in progress; a result waiting in the output
// register does not hold off the next word.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dirty_rect_list_merger (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire drlm_pkg::t_func  i_func,
    input  wire drlm_pkg::t_coord i_rect_left,
    input  wire drlm_pkg::t_coord i_rect_top,
    input  wire drlm_pkg::t_coord i_rect_right,
    input  wire drlm_pkg::t_coord i_rect_bottom,

    output logic                  o_valid,
    input  wire logic             i_ready,
    output drlm_pkg::t_coord      o_out_left,
    output drlm_pkg::t_coord      o_out_top,
    output drlm_pkg::t_coord      o_out_right,
    output drlm_pkg::t_coord      o_out_bottom,
    output logic                  o_has_rect,
    output drlm_pkg::t_count      o_entry_count,
    output logic                  o_was_merged,
    output logic                  o_full_drop,
    output logic                  o_is_last
);

    import drlm_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_ADD_RD  = 15'b000000000000010,
        S_ADD_LD  = 15'b000000000000100,
        S_ADD_CMP = 15'b000000000001000,
        S_MRG_I   = 15'b000000000010000,
        S_MRG_IL  = 15'b000000000100000,
        S_MRG_J   = 15'b000000001000000,
        S_MRG_JL  = 15'b000000010000000,
        S_MRG_CMP = 15'b000000100000000,
        S_SH_CHK  = 15'b000001000000000,
        S_SH_WR   = 15'b000010000000000,
        S_DMP_RD  = 15'b000100000000000,
        S_DMP_LD  = 15'b001000000000000,
        S_DMP_OUT = 15'b010000000000000,
        S_RESP    = 15'b100000000000000
    } t_state;

    // sequencer state
    t_state r_state, n_state;
    t_idx   r_head,  n_head;
    t_count r_count, n_count;
    t_count r_i, n_i;
    t_count r_j, n_j;
    t_count r_k, n_k;
    t_rect  r_a, n_a;      // entry i / front entry / entry being dumped
    t_rect  r_b, n_b;      // entry j / new rectangle
    logic   r_merged, n_merged;
    logic   r_drop,   n_drop;

    // output register
    logic   r_o_valid, n_o_valid;
    t_rect  r_o_rect,  n_o_rect;
    logic   r_o_has,   n_o_has;
    t_count r_o_count, n_o_count;
    logic   r_o_merged, n_o_merged;
    logic   r_o_drop,  n_o_drop;
    logic   r_o_last,  n_o_last;

    // RAM side
    logic   ram_we;
    t_idx   ram_waddr;
    t_rect  ram_wdata;
    t_idx   ram_raddr;
    t_rect  ram_rdata;

    // shared address unit and compare/union unit
    t_count             idx_sel;
    logic [SUM_W-1:0]   phys_sum;
    t_idx               phys;
    t_idx               head_dec;
    logic               hit;
    t_rect              uni;

    logic   out_free;
    logic   in_acc;
    t_count j_inc, k_inc;

    assign out_free = !r_o_valid || i_ready;
    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign j_inc    = CNT_W'(r_j + 1'b1);
    assign k_inc    = CNT_W'(r_k + 1'b1);

    assign hit = rect_ovl(r_a, r_b);
    assign uni = rect_union(r_a, r_b);

    // logical index -> ring slot
    always_comb begin
        unique case (r_state)
            S_MRG_I, S_MRG_CMP: idx_sel = r_i;
            S_MRG_J:            idx_sel = r_j;
            S_SH_CHK:           idx_sel = k_inc;
            S_SH_WR, S_DMP_RD:  idx_sel = r_k;
            default:            idx_sel = '0;
        endcase
        phys_sum = SUM_W'(r_head) + SUM_W'(idx_sel);
        if (phys_sum >= SUM_W'(MAX_RECTS)) begin
            phys_sum = phys_sum - SUM_W'(MAX_RECTS);
        end
        phys     = phys_sum[IDX_W-1:0];
        head_dec = (r_head == '0) ? IDX_W'(MAX_RECTS - 1) : IDX_W'(r_head - 1'b1);
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_a        = r_a;
        n_b        = r_b;
        n_merged   = r_merged;
        n_drop     = r_drop;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_rect   = r_o_rect;
        n_o_has    = r_o_has;
        n_o_count  = r_o_count;
        n_o_merged = r_o_merged;
        n_o_drop   = r_o_drop;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = phys;
        ram_wdata  = uni;
        ram_raddr  = phys;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_merged = 1'b0;
                    n_drop   = 1'b0;
                    unique case (i_func)
                        F_ADD: begin
                            n_b     = '{l: i_rect_left, t: i_rect_top,
                                        r: i_rect_right, b: i_rect_bottom};
                            n_state = S_ADD_RD;
                        end
                        F_MERGE: begin
                            n_i     = '0;
                            n_state = S_MRG_I;
                        end
                        F_CLEAR: begin
                            n_count = '0;
                            n_state = S_RESP;
                        end
                        F_DUMP: begin
                            n_k     = '0;
                            n_state = (r_count == '0) ? S_RESP : S_DMP_RD;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end

            // front entry read at logical index 0
            S_ADD_RD: n_state = S_ADD_LD;
            S_ADD_LD: begin
                n_a     = ram_rdata;
                n_state = S_ADD_CMP;
            end
            S_ADD_CMP: begin
                priority if (r_count != '0 && hit) begin
                    ram_we   = 1'b1;
                    n_merged = 1'b1;
                end else if (r_count >= CNT_W'(MAX_RECTS)) begin
                    n_drop   = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = head_dec;
                    ram_wdata = r_b;
                    n_head    = head_dec;
                    n_count   = CNT_W'(r_count + 1'b1);
                end
                n_state = S_RESP;
            end

            // scan row i; done once no later entry is left
            S_MRG_I: begin
                if (SUM_W'(r_i) + 1'b1 >= SUM_W'(r_count)) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_MRG_IL;
                end
            end
            S_MRG_IL: begin
                n_a     = ram_rdata;
                n_j     = CNT_W'(r_i + 1'b1);
                n_state = S_MRG_J;
            end
            S_MRG_J:  n_state = S_MRG_JL;
            S_MRG_JL: begin
                n_b     = ram_rdata;
                n_state = S_MRG_CMP;
            end
            S_MRG_CMP: begin
                if (hit) begin
                    ram_we  = 1'b1;
                    n_k     = r_j;
                    n_state = S_SH_CHK;
                end else if (j_inc < r_count) begin
                    n_j     = j_inc;
                    n_state = S_MRG_J;
                end else begin
                    n_i     = CNT_W'(r_i + 1'b1);
                    n_state = S_MRG_I;
                end
            end

            // close the gap at j, then rescan from the front
            S_SH_CHK: begin
                if (k_inc < r_count) begin
                    n_state = S_SH_WR;
                end else begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_i     = '0;
                    n_state = S_MRG_I;
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_k       = k_inc;
                n_state   = S_SH_CHK;
            end

            S_DMP_RD: n_state = S_DMP_LD;
            S_DMP_LD: begin
                n_a     = ram_rdata;
                n_state = S_DMP_OUT;
            end
            S_DMP_OUT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_rect   = r_a;
                    n_o_has    = 1'b1;
                    n_o_count  = r_count;
                    n_o_merged = 1'b0;
                    n_o_drop   = 1'b0;
                    n_o_last   = (k_inc == r_count);
                    n_k        = k_inc;
                    n_state    = (k_inc == r_count) ? S_IDLE : S_DMP_RD;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_rect   = '0;
                    n_o_has    = 1'b0;
                    n_o_count  = r_count;
                    n_o_merged = r_merged;
                    n_o_drop   = r_drop;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_a        <= n_a;
        r_b        <= n_b;
        r_merged   <= n_merged;
        r_drop     <= n_drop;
        r_o_rect   <= n_o_rect;
        r_o_has    <= n_o_has;
        r_o_count  <= n_o_count;
        r_o_merged <= n_o_merged;
        r_o_drop   <= n_o_drop;
        r_o_last   <= n_o_last;
    end

    drlm_ram #(
        .WIDTH ($bits(t_rect)),
        .DEPTH (MAX_RECTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_out_left    = r_o_rect.l;
    assign o_out_top     = r_o_rect.t;
    assign o_out_right   = r_o_rect.r;
    assign o_out_bottom  = r_o_rect.b;
    assign o_has_rect    = r_o_has;
    assign o_entry_count = r_o_count;
    assign o_was_merged  = r_o_merged;
    assign o_full_drop   = r_o_drop;
    assign o_is_last     = r_o_last;

    `DRLM_ASSERT(a_count_bound, r_count <= CNT_W'(MAX_RECTS), "list count above capacity")
    `DRLM_ASSERT(a_single_last, o_valid && !o_has_rect |-> o_is_last,
                 "non-dump result not marked last")
    `DRLM_ASSERT(a_dump_count, o_valid && o_has_rect |-> o_entry_count != '0,
                 "dumped entry from an empty list")
    `DRLM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid && o_ready,
                        "not idle after reset")

endmodule

`default_nettype wire
